// ===== hw/rtl/ctcg_pkg.sv =====
// Shared types, constants and tables for the CTC greedy decoder.
package ctcg_pkg;

  localparam int MaxClasses = 64;
  localparam int PosW       = $clog2(MaxClasses);
  localparam int AlphaLen   = 37;
  localparam int CountMax   = 127;

  // Alphabet characters, first character in the top byte
  localparam logic [8*AlphaLen-1:0] AlphaStr = "##0123456789ABCDEFGHIJKLMNPQRSTUVWXYZ";

  // Configuration register indexes
  localparam logic [0:0] RegThreshold  = 1'b0;
  localparam logic [0:0] RegClassCount = 1'b1;

  // One logit as it travels from front to back
  typedef struct packed {
    logic signed [15:0] logit;
    logic               last_in_step;
    logic               last_in_sequence;
  } req_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       char_valid;
    logic       text_done;
    logic       text_accepted;
  } res_t;

  // exp(-2^k/256) in Q16
  function automatic logic [15:0] exp_tab(input logic [3:0] k);
    logic [15:0] v;
    unique case (k)
      4'd0:  v = 16'd65280;
      4'd1:  v = 16'd65026;
      4'd2:  v = 16'd64520;
      4'd3:  v = 16'd63520;
      4'd4:  v = 16'd61565;
      4'd5:  v = 16'd57835;
      4'd6:  v = 16'd51039;
      4'd7:  v = 16'd39750;
      4'd8:  v = 16'd24109;
      4'd9:  v = 16'd8869;
      4'd10: v = 16'd1200;
      4'd11: v = 16'd22;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // Alphabet ROM: class index to ASCII
  function automatic logic [6:0] alpha_rom(input logic [PosW-1:0] c);
    logic [6:0] v;
    v = 7'd0;
    for (int i = 0; i < AlphaLen; i++) begin
      if (c == PosW'(i)) v = AlphaStr[8*(AlphaLen-1-i) +: 7];
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/ctcg_if.sv =====
// Valid/ready stream channel carrying one payload.
interface ctcg_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ctcg_ram.sv =====
// Generic single-port-write RAM with registered read.
module ctcg_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/ctcg_fifo.sv =====
// Short queue between the front and the back.
module ctcg_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ctcg_pkg::req_t push_data,
  output logic          full,
  input  logic          pop,
  output ctcg_pkg::req_t pop_data,
  output logic          empty
);
  import ctcg_pkg::*;
  req_t       q [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;

  assign full     = cnt == 3'd4;
  assign empty    = cnt == 3'd0;
  assign pop_data = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= push_data;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop)  rp <= rp + 2'd1;
      cnt <= cnt + 3'(push) - 3'(pop);
    end
  end
endmodule

// ===== hw/rtl/ctcg_back.sv =====
// Back end: row buffer, argmax, exp sum, reciprocal, emit and verdict.
module ctcg_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [15:0]    thresh,
  input  logic [6:0]     class_count,
  input  logic           req_valid,
  input  ctcg_pkg::req_t req,
  output logic           req_pop,
  output logic           res_valid,
  output ctcg_pkg::res_t res,
  input  logic           res_ready,
  output logic           busy
);
  import ctcg_pkg::*;

  typedef enum logic [3:0] {
    S_COLLECT, S_EXP_RD, S_EXP_LD, S_EXP_MUL, S_DIV, S_EMIT, S_CHAR, S_CMP, S_VERDICT
  } state_t;

  state_t          state;
  logic [PosW-1:0] pos, last_pos, rd_pos, best, prev_class;
  logic            prev_valid, seq_end, found_max;
  logic signed [15:0] mx;
  logic [15:0]     rdata;
  logic [15:0]     d;
  logic [3:0]      bitk;
  logic [16:0]     e;
  logic [22:0]     sum;
  logic [22:0]     prob_sum;
  logic [6:0]      emitted;
  logic [33:0]     rem;
  logic [5:0]      divi;
  logic [16:0]     quo;
  logic [38:0]     thr_prod;
  logic [6:0]      cc_eff;
  logic            wr_en;
  logic [PosW-1:0] wr_pos, p_clip;

  // Clamp class count to 2..MaxClasses
  always_comb begin
    if (class_count < 7'd2) cc_eff = 7'd2;
    else if (class_count > 7'(MaxClasses)) cc_eff = 7'(MaxClasses);
    else cc_eff = class_count;
  end

  assign p_clip  = (7'(pos) >= cc_eff) ? PosW'(cc_eff - 7'd1) : pos;
  assign req_pop = (state == S_COLLECT) && req_valid;
  assign wr_en   = req_pop;
  assign wr_pos  = p_clip;
  assign busy    = (state != S_COLLECT);

  ctcg_ram #(.Width(16), .Depth(MaxClasses)) u_row (
    .clk, .we(wr_en), .waddr(wr_pos), .wdata(req.logit),
    .raddr(rd_pos), .rdata
  );

  // Exp multiply step
  logic [32:0] mprod;
  assign mprod = e * exp_tab(bitk) + 33'd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COLLECT; pos <= '0; prev_class <= '0; prev_valid <= 1'b0;
      prob_sum <= '0; emitted <= '0; res_valid <= 1'b0;
    end else begin
      unique case (state)
        // Write logits; on step end scan the row for the max
        S_COLLECT: if (req_valid) begin
          if (req.last_in_step) begin
            last_pos <= p_clip; pos <= '0; seq_end <= req.last_in_sequence;
            rd_pos <= '0; found_max <= 1'b0; sum <= '0; state <= S_EXP_RD;
          end else if (7'(p_clip) < cc_eff - 7'd1) pos <= p_clip + 1'b1;
          else pos <= p_clip;
        end
        // First pass (found_max=0) finds the max, second sums exp terms
        S_EXP_RD: state <= S_EXP_LD;
        S_EXP_LD: begin
          if (!found_max) begin
            if (rd_pos == '0 || $signed(rdata) > mx) begin
              mx <= $signed(rdata); best <= rd_pos;
            end
            if (rd_pos == last_pos) begin
              found_max <= 1'b1; rd_pos <= '0;
            end else rd_pos <= rd_pos + 1'b1;
            state <= S_EXP_RD;
          end else begin
            d <= 16'(mx - $signed(rdata));
            e <= 17'd65536; bitk <= '0;
            state <= S_EXP_MUL;
          end
        end
        // Gap of 16.0 or more gives a zero term at once
        S_EXP_MUL: begin
          if (bitk == 4'd12) begin
            sum <= sum + 23'(e);
            if (rd_pos == last_pos) begin
              rem <= 34'd0; divi <= 6'd0; quo <= '0; state <= S_DIV;
            end else begin
              rd_pos <= rd_pos + 1'b1; state <= S_EXP_RD;
            end
          end else if (d[15:12] != 4'd0) begin
            e <= '0; bitk <= 4'd12;
          end else begin
            if (d[bitk]) e <= 17'(mprod >> 16);
            bitk <= bitk + 4'd1;
          end
        end
        // 34 bit dividend: 2^32 + sum/2, one quotient bit a cycle
        S_DIV: begin
          if (divi == 6'd0) begin
            rem <= 34'(35'(34'h1_0000_0000 + 34'(sum >> 1)) >> 33);
            divi <= 6'd1;
          end else begin
            logic [33:0] num;
            logic        nb;
            num = 34'h1_0000_0000 + 34'(sum >> 1);
            nb  = num[6'd33 - divi];
            if (({rem, nb} >= {12'd0, sum}))begin
              rem <= 34'({rem, nb} - {12'd0, sum}); quo <= {quo[15:0], 1'b1};
            end else begin
              rem <= 34'({rem, nb}); quo <= {quo[15:0], 1'b0};
            end
            if (divi == 6'd33) state <= S_EMIT;
            else divi <= divi + 6'd1;
          end
        end
        S_EMIT: begin
          if (best != '0 && !(prev_valid && best == prev_class)) begin
            res <= '{char_code: alpha_rom(best), char_valid: 1'b1,
                     text_done: 1'b0, text_accepted: 1'b0};
            res_valid <= 1'b1;
            if (emitted < 7'(CountMax)) begin
              prob_sum <= prob_sum + 23'((quo[16] || quo[15:0] == 16'hFFFF) ? 16'hFFFF
                                          : quo[15:0]);
              emitted <= emitted + 7'd1;
            end
            state <= S_CHAR;
          end else state <= seq_end ? S_CMP : S_COLLECT;
          prev_class <= best; prev_valid <= 1'b1;
        end
        S_CHAR: if (res_ready) begin
          res_valid <= 1'b0;
          state <= seq_end ? S_CMP : S_COLLECT;
        end
        S_CMP: begin
          res <= '{char_code: 7'd0, char_valid: 1'b0, text_done: 1'b1,
                   text_accepted: (emitted != 7'd0) && (39'(prob_sum) > thr_prod)};
          res_valid <= 1'b1; state <= S_VERDICT;
        end
        S_VERDICT: if (res_ready) begin
          res_valid <= 1'b0; prob_sum <= '0; emitted <= '0;
          prev_valid <= 1'b0; prev_class <= '0; state <= S_COLLECT;
        end
        default: state <= S_COLLECT;
      endcase
    end
  end

  always_ff @(posedge clk) thr_prod <= 39'(thresh) * 39'(emitted);
endmodule

// ===== hw/rtl/ctcg_front.sv =====
// Front end: accepts logit requests and pushes them into the queue.
module ctcg_front (
  ctcg_if.sink           in_ch,
  output logic           push,
  output ctcg_pkg::req_t push_data,
  input  logic           full
);
  import ctcg_pkg::*;
  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;
  assign push_data   = in_ch.data;
endmodule

// ===== hw/rtl/ctc_greedy_decoder.sv =====
// CTC greedy decoder: one logit per request in, characters and verdict out.
// Logits are taken one a cycle into a four-entry queue while it has room. The
// back end writes each into the row RAM; at the end of a step it rereads the row
// to find the argmax, rereads it again to sum the exp terms (bit-serial through
// a 12-entry table, with a zero term at once when the gap to the max is 16.0 or
// more), then runs a bit-serial divider for the peak probability. While it does
// so it takes no new logits from the queue.
module ctc_greedy_decoder (
  input  logic        clk,
  input  logic        rst,
  ctcg_if.sink        in_ch,
  ctcg_if.source      out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ctcg_pkg::*;

  logic [15:0] thresh;
  logic [6:0]  class_count;
  logic        push, full, pop, empty, busy;
  req_t        push_data, pop_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= 16'd58982; class_count <= 7'd37;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegThreshold:  thresh <= cfg_data;
        RegClassCount: class_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  ctcg_front u_front (.in_ch, .push, .push_data, .full);
  ctcg_fifo u_fifo (.clk, .rst, .push, .push_data, .full,
                    .pop, .pop_data, .empty);
  ctcg_back u_back (.clk, .rst, .thresh, .class_count,
                    .req_valid(!empty), .req(pop_data), .req_pop(pop),
                    .res_valid(out_ch.valid), .res(out_ch.data),
                    .res_ready(out_ch.ready), .busy);

  // Checks
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_out_busy: assert property (@(posedge clk) disable iff (rst) out_ch.valid |-> busy)
    else $error("result shown while idle");
endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the CTC greedy decoder: random and directed logit streams.
`timescale 1ns / 1ps

module testbench;
  import ctcg_pkg::*;

  // Decoder scoreboard: tracks step/sequence state and predicts characters and verdicts
  class decode_scoreboard;
    logic [15:0] threshold;
    logic [6:0]  classes_reg;
    logic signed [15:0] row[MaxClasses];
    int unsigned slot;
    int unsigned prev_cls;
    bit          prev_ok;
    logic [22:0] prob_sum;
    logic [6:0]  char_cnt;
    res_t        pending_q[$];
    int          mismatches;

    function new();
      threshold   = 16'd58982;
      classes_reg = 7'd37;
      slot = 0; prev_cls = 0; prev_ok = 0; prob_sum = '0; char_cnt = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [15:0] val);
      if (idx == RegThreshold) threshold = val;
      else classes_reg = val[6:0];
    endfunction

    function int unsigned active_classes();
      int unsigned c;
      c = classes_reg;
      if (c < 2) c = 2;
      if (c > MaxClasses) c = MaxClasses;
      return c;
    endfunction

    // exp(-d/256) in Q16, bit-serial over the exp(-2^k/256) constants
    function longint unsigned exp_term(int unsigned d);
      longint unsigned steps[12] = '{65280, 65026, 64520, 63520, 61565, 57835,
                                     51039, 39750, 24109, 8869, 1200, 22};
      longint unsigned e;
      e = 65536;
      if (d >= 4096) return 0;
      for (int k = 0; k < 12; k++)
        if (d[k]) e = (e * steps[k] + 32768) >> 16;
      return e;
    endfunction

    // Accepted logit request: update state and queue the results it causes
    function void note_request(req_t r);
      string          alpha;
      int unsigned    cc, n, best, sum;
      int             mx;
      longint unsigned q, prob;
      res_t           res;
      alpha = "##0123456789ABCDEFGHIJKLMNPQRSTUVWXYZ";
      cc = active_classes();
      if (slot >= cc) slot = cc - 1;
      row[slot] = r.logit;
      if (!r.last_in_step) begin
        if (slot < cc - 1) slot++;
        return;
      end
      n = slot + 1;
      slot = 0;
      best = 0;
      mx = row[0];
      for (int i = 1; i < n; i++)
        if (int'(row[i]) > mx) begin
          mx = row[i];
          best = i;
        end
      sum = 0;
      for (int i = 0; i < n; i++) sum += exp_term(mx - int'(row[i]));
      q = ((64'd1 << 32) + sum / 2) / sum;
      prob = (q > 65535) ? 65535 : q;
      if (best != 0 && !(prev_ok && best == prev_cls)) begin
        res = '0;
        res.char_valid = 1'b1;
        res.char_code = (best < AlphaLen) ? 7'(alpha.getc(best)) : 7'd0;
        pending_q = {pending_q, res};
        if (char_cnt < CountMax) begin
          prob_sum += prob;
          char_cnt++;
        end
      end
      prev_cls = best & 6'h3f;
      prev_ok = 1;
      if (r.last_in_sequence) begin
        res = '0;
        res.text_done = 1'b1;
        res.text_accepted = (char_cnt > 0) &&
                            (64'(prob_sum) > 64'(threshold) * 64'(char_cnt));
        pending_q = {pending_q, res};
        prob_sum = '0; char_cnt = '0; prev_ok = 0; prev_cls = 0;
      end
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: code=%0d cv=%0b done=%0b acc=%0b",
                   got.char_code, got.char_valid, got.text_done, got.text_accepted);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.char_code !== exp_r.char_code || got.char_valid !== exp_r.char_valid ||
          got.text_done !== exp_r.text_done || got.text_accepted !== exp_r.text_accepted)
      begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp code=%0d cv=%0b done=%0b acc=%0b,",
                    " got code=%0d cv=%0b done=%0b acc=%0b"},
                   exp_r.char_code, exp_r.char_valid, exp_r.text_done,
                   exp_r.text_accepted, got.char_code, got.char_valid,
                   got.text_done, got.text_accepted);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;

  ctcg_if #(.payload_t(req_t)) in_if (clk);
  ctcg_if #(.payload_t(res_t)) out_if (clk);

  ctc_greedy_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  decode_scoreboard sb = new();
  int  sent_count;
  bit  steady;        // no idling on either side
  int  hold_cycles;   // receiver hold-off request
  int  prev_winner;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("[ctc_greedy_decoder] ERROR");
    $finish;
  end

  // Receiver: random stalls plus the long hold-off, counted here
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady || ($urandom_range(0, 99) >= 26);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Drain expected results, then let any step without results finish
  task automatic wait_idle();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  task automatic send(logic signed [15:0] lg, logic ls, logic lq);
    req_t r;
    r.logit = lg;
    r.last_in_step = ls;
    r.last_in_sequence = lq;
    if (!steady && $urandom_range(0, 99) < 26) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= r;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(r);
    sent_count++;
  endtask

  function automatic logic signed [15:0] clamp16(int v);
    if (v < -32768) return 16'sh8000;
    if (v > 32767) return 16'sh7fff;
    return 16'(v);
  endfunction

  // One time step of n logits; spread 0 means raw random values
  task automatic drive_step(int n, int winner, int spread, bit tie, bit seq_end);
    int win, v;
    win = int'($urandom_range(0, 40000)) - 20000;
    for (int i = 0; i < n; i++) begin
      if (spread == 0) v = $signed(16'($urandom));
      else if (i == winner) v = win;
      else if (tie && i > winner && $urandom_range(0, 1)) v = win;
      else v = win - int'($urandom_range(1, spread));
      send(clamp16(v), i == n - 1,
           (i == n - 1) ? seq_end : ($urandom_range(0, 99) < 5));
    end
  endtask

  // A random sequence shaped for class count c
  task automatic rand_sequence(int c);
    int steps, n, w, spread, pick;
    steps = $urandom_range(1, 6);
    for (int s = 0; s < steps; s++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) n = c;
      else if (pick < 90) n = $urandom_range(1, c);
      else n = c + $urandom_range(1, 3);
      pick = $urandom_range(0, 99);
      if (pick < 30) w = 0;
      else if (pick < 55) w = prev_winner;
      else w = $urandom_range(1, c - 1);
      if (w >= n) w = n - 1;
      if (w >= c - 1 && n > c) w = c - 2;
      pick = $urandom_range(0, 9);
      spread = (pick == 0) ? 0 : (pick < 4) ? 200 : (pick < 7) ? 2000 : 12000;
      prev_winner = w;
      drive_step(n, w, spread, $urandom_range(0, 9) == 0, s == steps - 1);
    end
  endtask

  task automatic run_phase(logic [15:0] thr, logic [6:0] cc, int items,
                           bit no_idle, int hold);
    int c;
    wait_idle();
    write_reg(RegThreshold, thr);
    write_reg(RegClassCount, {9'd0, cc});
    c = sb.active_classes();
    steady = no_idle;
    hold_cycles = hold;
    items += sent_count;
    while (sent_count < items) rand_sequence(c);
    in_if.valid <= 1'b0;
    steady = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= RegThreshold;
    cfg_data <= '0;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    sent_count = 0;
    steady = 1'b0;
    hold_cycles = 0;
    prev_winner = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, ties, short steps, repeats, empty text (reset config)
    send(16'sd32767, 1'b0, 1'b1);           // sequence flag without step end
    send(16'sh8000, 1'b1, 1'b0);            // short step, blank wins
    send(16'sh8000, 1'b0, 1'b0);
    send(16'sd32767, 1'b0, 1'b0);
    send(16'sd32767, 1'b1, 1'b0);           // tie, lowest index wins
    send(16'sh8000, 1'b0, 1'b0);
    send(16'sd32767, 1'b1, 1'b0);           // same class repeated: no character
    send(16'sd0, 1'b0, 1'b0);
    send(16'sd0, 1'b1, 1'b0);               // blank tie
    send(16'sh8000, 1'b0, 1'b0);
    send(16'sd32767, 1'b1, 1'b1);           // repeat after blank emits again
    send(16'sd100, 1'b0, 1'b0);
    send(16'sd99, 1'b0, 1'b0);
    send(16'sd98, 1'b1, 1'b1);              // empty text
    send(-16'sd1, 1'b0, 1'b0);
    send(-16'sd2, 1'b0, 1'b0);
    send(16'sd5000, 1'b1, 1'b1);            // sharp peak, high confidence
    in_if.valid <= 1'b0;

    run_phase(16'd0, 7'd2, 80, 1'b0, 0);
    run_phase(16'd65535, 7'd64, 120, 1'b0, 0);
    run_phase(16'($urandom_range(40000, 65000)), 7'd5, 120, 1'b1, 0);
    run_phase(16'($urandom), 7'd1, 80, 1'b0, 3000);
    run_phase(16'd50000, 7'd127, 70, 1'b0, 0);

    // Count saturation: alternating classes 1 and 2, 132 characters (more than 127)
    wait_idle();
    write_reg(RegThreshold, 16'd60000);
    write_reg(RegClassCount, 16'd3);
    for (int s = 0; s < 132; s++) begin
      if (s[0]) drive_step(3, 2, 3000, 1'b0, s == 131);
      else drive_step(2, 1, 3000, 1'b0, 1'b0);
    end
    in_if.valid <= 1'b0;

    run_phase(16'($urandom), 7'd37, 40, 1'b0, 0);

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("[ctc_greedy_decoder] OK");
    end else begin
      $display("[ctc_greedy_decoder] ERROR");
    end
    $finish;
  end

endmodule

// ===== ctc_greedy_decoder.f =====
hw/rtl/ctcg_pkg.sv
hw/rtl/ctcg_if.sv
hw/rtl/ctcg_ram.sv
hw/rtl/ctcg_fifo.sv
hw/rtl/ctcg_back.sv
hw/rtl/ctcg_front.sv
hw/rtl/ctc_greedy_decoder.sv
sim/testbench.sv
